>>> rtl/core/wfha_pkg.sv
// Shared types, constants and helpers for the worst-fit heap allocator.
// Used by wfha_hdr_ram, wfha_ctrl and worst_fit_heap_allocator; depends on nothing.
package wfha_pkg;

  // Arena geometry
  localparam int ARENA_BYTES  = 4096;
  localparam int HEADER_BYTES = 10;
  localparam int OFF_W        = 12;   // byte offset inside the arena
  localparam int SIZE_W       = 13;   // payload size or arena span
  localparam int MIN_SPAN     = HEADER_BYTES + 1;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NO_FIT    = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // One block header as stored in the header memory
  typedef struct packed {
    logic              used;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  // Header memory access from one cycle
  typedef struct packed {
    logic             we;
    logic [OFF_W-1:0] waddr;
    hdr_t             wdata;
    logic             re;
    logic [OFF_W-1:0] raddr;
  } mem_req_t;

  // Finished result of one request
  typedef struct packed {
    logic [OFF_W-1:0] address;
    logic [1:0]       status;
  } res_t;

  // Usable arena span for a written arena_size: clamped to the arena, zero when too small.
  function automatic logic [SIZE_W-1:0] span_of(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] s;
    begin
      s = v;
      if (v > SIZE_W'(ARENA_BYTES)) begin
        s = SIZE_W'(ARENA_BYTES);
      end else if (v < SIZE_W'(MIN_SPAN)) begin
        s = '0;
      end
      return s;
    end
  endfunction

endpackage

>>> rtl/core/wfha_hdr_ram.sv
// Header memory: one header per arena byte offset, one write and one read port.
// Read data is registered. Depends on wfha_pkg.
module wfha_hdr_ram (
  input  logic                      clk,
  input  wfha_pkg::mem_req_t        req,
  output wfha_pkg::hdr_t            rdata
);

  wfha_pkg::hdr_t mem [wfha_pkg::ARENA_BYTES];

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

>>> rtl/core/wfha_ctrl.sv
// Request sequencer: walks block headers one memory read per cycle, then
// splits, marks or merges blocks by read-modify-write. Depends on wfha_pkg.
module wfha_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [wfha_pkg::SIZE_W-1:0]     span,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_kind,
  input  logic [wfha_pkg::SIZE_W-1:0]     in_request_size,
  input  logic [wfha_pkg::OFF_W-1:0]      in_free_address,
  output wfha_pkg::mem_req_t              mem_req,
  input  wfha_pkg::hdr_t                  rd_hdr,
  output logic                            res_valid,
  input  logic                            res_ready,
  output wfha_pkg::res_t                  res
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK   = 3'd1;
  localparam logic [2:0] S_ADEC   = 3'd2;
  localparam logic [2:0] S_AMARK  = 3'd3;
  localparam logic [2:0] S_FNXT   = 3'd4;
  localparam logic [2:0] S_FPRV   = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  localparam logic [wfha_pkg::SIZE_W-1:0] HB13 = wfha_pkg::SIZE_W'(wfha_pkg::HEADER_BYTES);
  localparam logic [wfha_pkg::OFF_W-1:0]  HB12 = wfha_pkg::OFF_W'(wfha_pkg::HEADER_BYTES);
  localparam logic [13:0]                 HB14 = 14'(wfha_pkg::HEADER_BYTES);

  logic [2:0]                    st_r, st_nxt;
  logic                          kind_r, kind_nxt;
  logic [wfha_pkg::SIZE_W-1:0]   req_r, req_nxt;
  logic [wfha_pkg::OFF_W-1:0]    tgt_r, tgt_nxt;
  logic [wfha_pkg::OFF_W-1:0]    walk_r, walk_nxt;
  logic                          found_r, found_nxt;
  logic [wfha_pkg::OFF_W-1:0]    best_off_r, best_off_nxt;
  logic [wfha_pkg::SIZE_W-1:0]   best_size_r, best_size_nxt;
  logic                          have_prev_r, have_prev_nxt;
  logic [wfha_pkg::OFF_W-1:0]    prev_off_r, prev_off_nxt;
  wfha_pkg::hdr_t                prev_hdr_r, prev_hdr_nxt;
  logic [wfha_pkg::SIZE_W-1:0]   cur_size_r, cur_size_nxt;
  wfha_pkg::res_t                res_r, res_nxt;

  // Walk arithmetic on the header read in this cycle
  logic [13:0]                   next_off;
  logic                          at_end;
  logic                          is_target;
  logic                          take_best;
  logic                          split;
  logic                          fits;
  logic [wfha_pkg::SIZE_W-1:0]   merged_size;

  assign next_off  = 14'(walk_r) + HB14 + 14'(rd_hdr.size);
  assign at_end    = next_off >= {1'b0, span};
  assign is_target = rd_hdr.used && ((14'(walk_r) + HB14) == 14'(tgt_r));
  assign take_best = !rd_hdr.used && (!found_r || (rd_hdr.size > best_size_r));
  assign split     = {1'b0, best_size_r} > ({1'b0, req_r} + HB14);
  assign fits      = best_size_r >= req_r;
  assign merged_size = rd_hdr.used ? cur_size_r : (cur_size_r + HB13 + rd_hdr.size);

  assign in_ready  = (st_r == S_IDLE);
  assign res_valid = (st_r == S_FIN);
  assign res       = res_r;

  // Next-state and memory access decode
  always_comb begin
    st_nxt        = st_r;
    kind_nxt      = kind_r;
    req_nxt       = req_r;
    tgt_nxt       = tgt_r;
    walk_nxt      = walk_r;
    found_nxt     = found_r;
    best_off_nxt  = best_off_r;
    best_size_nxt = best_size_r;
    have_prev_nxt = have_prev_r;
    prev_off_nxt  = prev_off_r;
    prev_hdr_nxt  = prev_hdr_r;
    cur_size_nxt  = cur_size_r;
    res_nxt       = res_r;
    mem_req       = '0;

    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt      = in_kind;
          req_nxt       = in_request_size;
          tgt_nxt       = in_free_address;
          walk_nxt      = '0;
          found_nxt     = 1'b0;
          best_off_nxt  = '0;
          best_size_nxt = '0;
          have_prev_nxt = 1'b0;
          prev_off_nxt  = '0;
          if (span == '0) begin
            // Empty arena answers at once.
            res_nxt.address = '0;
            res_nxt.status  = (in_kind == wfha_pkg::KIND_ALLOC) ?
                              wfha_pkg::ST_NO_FIT : wfha_pkg::ST_NOT_FOUND;
            st_nxt = S_FIN;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = '0;
            st_nxt        = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (kind_r == wfha_pkg::KIND_ALLOC) begin
          // Track the earliest largest free block.
          if (take_best) begin
            found_nxt     = 1'b1;
            best_size_nxt = rd_hdr.size;
            best_off_nxt  = walk_r;
          end
          if (at_end) begin
            st_nxt = S_ADEC;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = next_off[wfha_pkg::OFF_W-1:0];
            walk_nxt      = next_off[wfha_pkg::OFF_W-1:0];
          end
        end else if (is_target) begin
          cur_size_nxt = rd_hdr.size;
          if (!at_end) begin
            // Fetch the next neighbor to see if it can be merged.
            mem_req.re    = 1'b1;
            mem_req.raddr = next_off[wfha_pkg::OFF_W-1:0];
            st_nxt        = S_FNXT;
          end else begin
            mem_req.we          = 1'b1;
            mem_req.waddr       = walk_r;
            mem_req.wdata.used  = 1'b0;
            mem_req.wdata.size  = rd_hdr.size;
            res_nxt.address     = '0;
            res_nxt.status      = wfha_pkg::ST_DONE;
            st_nxt = (have_prev_r && !prev_hdr_r.used) ? S_FPRV : S_FIN;
          end
        end else if (at_end) begin
          res_nxt.address = '0;
          res_nxt.status  = wfha_pkg::ST_NOT_FOUND;
          st_nxt          = S_FIN;
        end else begin
          have_prev_nxt = 1'b1;
          prev_off_nxt  = walk_r;
          prev_hdr_nxt  = rd_hdr;
          mem_req.re    = 1'b1;
          mem_req.raddr = next_off[wfha_pkg::OFF_W-1:0];
          walk_nxt      = next_off[wfha_pkg::OFF_W-1:0];
        end
      end

      S_ADEC: begin
        res_nxt.address = '0;
        res_nxt.status  = wfha_pkg::ST_NO_FIT;
        if (!found_r) begin
          st_nxt = S_FIN;
        end else if (split) begin
          // Carve the remainder off as a new free block after the grant.
          mem_req.we         = 1'b1;
          mem_req.waddr      = best_off_r + HB12 + req_r[wfha_pkg::OFF_W-1:0];
          mem_req.wdata.used = 1'b0;
          mem_req.wdata.size = best_size_r - HB13 - req_r;
          st_nxt             = S_AMARK;
        end else if (fits) begin
          mem_req.we         = 1'b1;
          mem_req.waddr      = best_off_r;
          mem_req.wdata.used = 1'b1;
          mem_req.wdata.size = best_size_r;
          res_nxt.address    = best_off_r + HB12;
          res_nxt.status     = wfha_pkg::ST_DONE;
          st_nxt             = S_FIN;
        end else begin
          st_nxt = S_FIN;
        end
      end

      S_AMARK: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = best_off_r;
        mem_req.wdata.used = 1'b1;
        mem_req.wdata.size = req_r;
        res_nxt.address    = best_off_r + HB12;
        res_nxt.status     = wfha_pkg::ST_DONE;
        st_nxt             = S_FIN;
      end

      S_FNXT: begin
        // Absorb a free next neighbor and release the block.
        mem_req.we         = 1'b1;
        mem_req.waddr      = walk_r;
        mem_req.wdata.used = 1'b0;
        mem_req.wdata.size = merged_size;
        cur_size_nxt       = merged_size;
        res_nxt.address    = '0;
        res_nxt.status     = wfha_pkg::ST_DONE;
        st_nxt = (have_prev_r && !prev_hdr_r.used) ? S_FPRV : S_FIN;
      end

      S_FPRV: begin
        // The free previous neighbor absorbs the released block.
        mem_req.we         = 1'b1;
        mem_req.waddr      = prev_off_r;
        mem_req.wdata.used = 1'b0;
        mem_req.wdata.size = prev_hdr_r.size + HB13 + cur_size_r;
        st_nxt             = S_FIN;
      end

      S_FIN: begin
        if (res_ready) begin
          st_nxt = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Walk and result registers
  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    req_r       <= req_nxt;
    tgt_r       <= tgt_nxt;
    walk_r      <= walk_nxt;
    found_r     <= found_nxt;
    best_off_r  <= best_off_nxt;
    best_size_r <= best_size_nxt;
    have_prev_r <= have_prev_nxt;
    prev_off_r  <= prev_off_nxt;
    prev_hdr_r  <= prev_hdr_nxt;
    cur_size_r  <= cur_size_nxt;
    res_r       <= res_nxt;
  end

endmodule

>>> rtl/core/worst_fit_heap_allocator.sv
// Top level of the worst-fit heap allocator: arena size register, header memory,
// request sequencer and output register. Depends on wfha_pkg, wfha_hdr_ram, wfha_ctrl.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_kind, in_request_size, in_free_address
//   out     | output    | out_valid / out_ready| out_address, out_status
//   cfg     | input     | cfg_wr_en            | cfg_wr_data (arena_size)
//
// A request is accepted, then the sequencer reads the header of each block in the
// arena (one block per cycle; a free stops at its target), then makes up to two
// header writes and hands the result to the output register.
// The single read port of the header memory sets that walk rate.
// Reset is synchronous and active low; the arena starts empty and needs no clearing pass.
// A result waiting in the output register holds the sequencer at the hand-off, so the
// next accept also waits until out_ready frees the output register.
module worst_fit_heap_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [wfha_pkg::SIZE_W-1:0]    in_request_size,
  input  logic [wfha_pkg::OFF_W-1:0]     in_free_address,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [wfha_pkg::OFF_W-1:0]     out_address,
  output logic [1:0]                     out_status,
  input  logic                           cfg_wr_en,
  input  logic [wfha_pkg::SIZE_W-1:0]    cfg_wr_data
);

  logic [wfha_pkg::SIZE_W-1:0] span_r, span_nxt;
  wfha_pkg::mem_req_t          ctrl_req;
  wfha_pkg::mem_req_t          ram_req;
  wfha_pkg::hdr_t              rd_hdr;
  logic                        res_valid;
  logic                        res_ready;
  wfha_pkg::res_t              res;
  logic                        out_valid_r, out_valid_nxt;
  wfha_pkg::res_t              out_r;

  // Arena size register holds the usable span.
  assign span_nxt = cfg_wr_en ? wfha_pkg::span_of(cfg_wr_data) : span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= '0;
    end else begin
      span_r <= span_nxt;
    end
  end

  // A configuration write with a nonzero span rebuilds the arena as one free block at offset zero.
  always_comb begin
    ram_req = ctrl_req;
    if (cfg_wr_en && (span_nxt != '0)) begin
      ram_req.we         = 1'b1;
      ram_req.waddr      = '0;
      ram_req.wdata.used = 1'b0;
      ram_req.wdata.size = span_nxt - wfha_pkg::SIZE_W'(wfha_pkg::HEADER_BYTES);
    end
  end

  wfha_hdr_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rd_hdr)
  );

  wfha_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .span            (span_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_request_size (in_request_size),
    .in_free_address (in_free_address),
    .mem_req         (ctrl_req),
    .rd_hdr          (rd_hdr),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res)
  );

  // Output register
  assign res_ready     = !out_valid_r || out_ready;
  assign out_valid_nxt = (res_valid && res_ready) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_address = out_r.address;
  assign out_status  = out_r.status;

  // A beat that is not a success never carries an address.
  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != wfha_pkg::ST_DONE) |-> out_address == '0)
    else $error("failed request carries an address");

  // A granted payload lies behind a header inside the arena.
  a_grant_in_arena: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_address != '0) |->
      (out_address >= wfha_pkg::OFF_W'(wfha_pkg::HEADER_BYTES)) &&
      ({1'b0, out_address} < span_r))
    else $error("granted address outside the arena");

  // The span is either empty or a legal arena size.
  a_span_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (span_r == '0) ||
      ((span_r >= wfha_pkg::SIZE_W'(wfha_pkg::MIN_SPAN)) &&
       (span_r <= wfha_pkg::SIZE_W'(wfha_pkg::ARENA_BYTES))))
    else $error("arena span out of range");

endmodule

>>> test/worst_fit_heap_allocator_tb.sv
// Self-checking testbench for worst_fit_heap_allocator: directed and random alloc/free traffic
// with bursty input, stalling output and arena size rewrites between phases.
// Depends on wfha_pkg and the worst_fit_heap_allocator RTL.
module worst_fit_heap_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wfha_pkg::*;

  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_e;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_kind;
  logic [SIZE_W-1:0] in_request_size;
  logic [OFF_W-1:0]  in_free_address;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [OFF_W-1:0]  out_address;
  logic [1:0]        out_status;
  logic              cfg_wr_en;
  logic [SIZE_W-1:0] cfg_wr_data;

  // Mirror of the arena: one header per byte offset, meaningful only at block starts.
  logic [SIZE_W-1:0] blk_size [ARENA_BYTES];
  bit                blk_used [ARENA_BYTES];
  logic [SIZE_W-1:0] arena_bytes;

  res_t pending_results [$];
  int   live_payloads [$];
  int   fail_count = 0;
  int   idle_cycles = 0;

  // Sender burst state and receiver stall state.
  int          burst_left = 0;
  bit          sender_gaps_on = 1'b1;
  int          hold_off_cycles = 0;
  ready_mode_e ready_mode = READY_ALWAYS;
  int          ready_left = 0;
  int          ready_phase = 0;

  worst_fit_heap_allocator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_request_size (in_request_size),
    .in_free_address (in_free_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_address     (out_address),
    .out_status      (out_status),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Usable arena bytes: clamped to the arena, zero when too small to hold one block.
  function automatic int arena_span();
    int s;
    s = int'(arena_bytes);
    if (s > ARENA_BYTES) s = ARENA_BYTES;
    if (s < MIN_SPAN) s = 0;
    return s;
  endfunction

  // The whole arena becomes one free block, or none when the span is zero.
  function automatic void rebuild_arena();
    int s;
    s = arena_span();
    for (int i = 0; i < ARENA_BYTES; i++) begin
      blk_size[i] = '0;
      blk_used[i] = 1'b0;
    end
    if (s != 0) blk_size[0] = SIZE_W'(s - HEADER_BYTES);
  endfunction

  // Worst fit: earliest largest free block, split when the remainder holds more than a header.
  function automatic res_t model_allocate(int req);
    res_t r;
    int   s;
    int   off;
    int   best_off;
    int   best_sz;
    int   nxt;
    bit   found;
    r.address = '0;
    r.status  = ST_NO_FIT;
    s = arena_span();
    found = 1'b0;
    best_off = 0;
    best_sz = 0;
    for (off = 0; off < s; off += HEADER_BYTES + int'(blk_size[off])) begin
      if (!blk_used[off] && (!found || int'(blk_size[off]) > best_sz)) begin
        found = 1'b1;
        best_sz = int'(blk_size[off]);
        best_off = off;
      end
    end
    if (!found) return r;
    if (best_sz > req + HEADER_BYTES) begin
      nxt = best_off + HEADER_BYTES + req;
      blk_size[nxt] = SIZE_W'(best_sz - HEADER_BYTES - req);
      blk_used[nxt] = 1'b0;
      blk_size[best_off] = SIZE_W'(req);
      blk_used[best_off] = 1'b1;
    end else if (best_sz >= req) begin
      blk_used[best_off] = 1'b1;
    end else begin
      return r;
    end
    r.address = OFF_W'(best_off + HEADER_BYTES);
    r.status  = ST_DONE;
    return r;
  endfunction

  // Release an allocated payload, merging with a free next and then a free previous block.
  function automatic res_t model_release(int target);
    res_t r;
    int   s;
    int   off;
    int   prev_off;
    int   nxt;
    bit   have_prev;
    r.address = '0;
    r.status  = ST_NOT_FOUND;
    s = arena_span();
    off = 0;
    prev_off = 0;
    have_prev = 1'b0;
    while (off < s) begin
      nxt = off + HEADER_BYTES + int'(blk_size[off]);
      if (blk_used[off] && off + HEADER_BYTES == target) begin
        if (nxt < s && !blk_used[nxt]) begin
          blk_size[off] = SIZE_W'(int'(blk_size[off]) + HEADER_BYTES + int'(blk_size[nxt]));
        end
        if (have_prev && !blk_used[prev_off]) begin
          blk_size[prev_off] =
            SIZE_W'(int'(blk_size[prev_off]) + HEADER_BYTES + int'(blk_size[off]));
        end
        blk_used[off] = 1'b0;
        r.status = ST_DONE;
        return r;
      end
      have_prev = 1'b1;
      prev_off = off;
      off = nxt;
    end
    return r;
  endfunction

  // Offer one request beat; the value is a request size or a payload offset by kind.
  // The unused field carries random data.
  task automatic send_request(input logic kind, input int value);
    int   gap;
    res_t grant;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = sender_gaps_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_kind  = kind;
    if (kind == KIND_ALLOC) begin
      in_request_size = SIZE_W'(value);
      in_free_address = OFF_W'($urandom_range(0, 4095));
    end else begin
      in_request_size = SIZE_W'($urandom_range(0, 4096));
      in_free_address = OFF_W'(value);
    end
    do @(posedge clk); while (!in_ready);

    // Beat accepted: predict and keep track of live payloads.
    if (kind == KIND_ALLOC) begin
      grant = model_allocate(int'(in_request_size));
      if (grant.status == ST_DONE) live_payloads.push_back(int'(grant.address));
    end else begin
      grant = model_release(int'(in_free_address));
      if (grant.status == ST_DONE) begin
        foreach (live_payloads[i]) begin
          if (live_payloads[i] == int'(in_free_address)) begin
            live_payloads.delete(i);
            break;
          end
        end
      end
    end
    pending_results.push_back(grant);
  endtask

  // Stop offering and wait until every expected result has been seen.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Arena size is rewritten only with the block idle.
  task automatic write_arena_size(input int value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = SIZE_W'(value);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    arena_bytes = SIZE_W'(value);
    rebuild_arena();
    live_payloads.delete();
  endtask

  // Empty arena after reset and a too-small arena.
  task automatic test_empty_arena();
    send_request(KIND_ALLOC, 0);
    send_request(KIND_FREE, 10);
    send_request(KIND_FREE, 0);
    write_arena_size(10);
    send_request(KIND_ALLOC, 5);
    send_request(KIND_FREE, 4095);
  endtask

  // Smallest usable arena: one block of a single payload byte.
  task automatic test_single_byte_arena();
    write_arena_size(MIN_SPAN);
    send_request(KIND_ALLOC, 0);
    send_request(KIND_ALLOC, 0);
    send_request(KIND_FREE, 10);
    send_request(KIND_ALLOC, 1);
    send_request(KIND_ALLOC, 2);
  endtask

  // Oversized arena write, largest requests and a grant at the very end of the arena.
  task automatic test_full_arena();
    write_arena_size(8191);
    send_request(KIND_ALLOC, 4096);
    send_request(KIND_ALLOC, 4086);
    send_request(KIND_FREE, 10);
    send_request(KIND_ALLOC, 4075);
    send_request(KIND_ALLOC, 0);
    send_request(KIND_FREE, 4095);
    send_request(KIND_FREE, 2048);
  endtask

  // Frees that merge with nothing, with the next block and with both neighbors.
  task automatic test_merge_neighbors();
    write_arena_size(300);
    send_request(KIND_ALLOC, 20);
    send_request(KIND_ALLOC, 20);
    send_request(KIND_ALLOC, 20);
    send_request(KIND_FREE, 10);
    send_request(KIND_FREE, 70);
    send_request(KIND_FREE, 40);
    send_request(KIND_FREE, 40);
    send_request(KIND_ALLOC, 20);
    send_request(KIND_FREE, 41);
  endtask

  // Long receiver hold-off fills the block, then the sender waits for all results.
  task automatic test_output_backpressure();
    write_arena_size(1024);
    sender_gaps_on = 1'b0;
    @(posedge clk);
    hold_off_cycles = 600;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2 && live_payloads.size() != 0) send_request(KIND_FREE, live_payloads[0]);
      else send_request(KIND_ALLOC, $urandom_range(0, 64));
    end
    wait_drained();
    sender_gaps_on = 1'b1;
  endtask

  // Mostly well-formed alloc/free sequences with some noise, over several arena sizes.
  task automatic test_random_traffic();
    int sizes [6];
    int counts [6];
    int s;
    int pick;
    int k;
    sizes  = '{4096, 512, 0, 64, 0, 2048};
    counts = '{130, 110, 110, 70, 20, 120};
    sizes[2] = $urandom_range(11, 4096);
    sizes[4] = $urandom_range(0, 10);
    for (int p = 0; p < 6; p++) begin
      write_arena_size(sizes[p]);
      s = arena_span();
      sender_gaps_on = $urandom_range(0, 1);
      for (int n = 0; n < counts[p]; n++) begin
        if (n == counts[p] / 2) sender_gaps_on = !sender_gaps_on;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          // Broken requests: stray offsets, mid-payload offsets and oversized requests.
          k = $urandom_range(0, 2);
          if (k == 0) send_request(KIND_FREE, $urandom_range(0, 4095));
          else if (k == 1 && live_payloads.size() != 0)
            send_request(KIND_FREE, live_payloads[$urandom_range(0, live_payloads.size() - 1)] + 1);
          else send_request(KIND_ALLOC, $urandom_range(0, 4096));
        end else if (pick < 50 && live_payloads.size() != 0) begin
          send_request(KIND_FREE, live_payloads[$urandom_range(0, live_payloads.size() - 1)]);
        end else begin
          k = $urandom_range(0, 99);
          if (k < 60) send_request(KIND_ALLOC, $urandom_range(0, 32));
          else if (k < 90) send_request(KIND_ALLOC, $urandom_range(33, 300));
          else send_request(KIND_ALLOC, $urandom_range(0, (s > 0) ? s : 4096));
        end
      end
    end
  endtask

  // Receiver: a long hold-off on request, otherwise switching stall patterns.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_ready = 1'b0;
      hold_off_cycles--;
    end else begin
      if (ready_left == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 2));
        ready_left = $urandom_range(20, 200);
      end
      ready_left--;
      ready_phase = (ready_phase + 1) % 7;
      case (ready_mode)
        READY_ALWAYS: out_ready = 1'b1;
        READY_RANDOM: out_ready = ($urandom_range(0, 99) < 60);
        default:      out_ready = (ready_phase >= 3);
      endcase
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    res_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: address %0d, status %0d", out_address, out_status);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_address !== exp_res.address) begin
          $error("address mismatch: expected %0d, actual %0d", exp_res.address, out_address);
          fail_count++;
        end
        if (out_status !== exp_res.status) begin
          $error("status mismatch: expected %0d, actual %0d", exp_res.status, out_status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_kind         = KIND_ALLOC;
    in_request_size = '0;
    in_free_address = '0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    arena_bytes     = '0;
    rebuild_arena();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_arena();
    test_single_byte_arena();
    test_full_arena();
    test_merge_neighbors();
    test_output_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/wfha_pkg.sv
rtl/core/wfha_hdr_ram.sv
rtl/core/wfha_ctrl.sv
rtl/core/worst_fit_heap_allocator.sv
test/worst_fit_heap_allocator_tb.sv
